// ===== src/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cbrp_pkg.sv =====
package cbrp_pkg;

  localparam int SQUARES_PER_LEVEL = 64;
  localparam int MAX_LEVELS        = 8;
  localparam int TOTAL_SQUARES     = MAX_LEVELS * SQUARES_PER_LEVEL;
  localparam int SQ_CNT_W          = $clog2(TOTAL_SQUARES + 1);
  localparam int SQ_IDX_W          = 9;
  localparam int WORD_W            = 32;
  localparam int CNT8_W            = 8;
  localparam int MAX_COUNT         = 256;

  localparam logic [WORD_W-1:0] SKIP_MARK = '1;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_TILE   = 2'd1,
    KIND_FINISH = 2'd2
  } cbrp_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RUN   = 3'd1,
    ST_OVERSHOOT = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_TOO_MANY  = 3'd4,
    ST_TRUNCATED = 3'd5
  } cbrp_status_t;

  typedef enum logic [3:0] {
    PH_COUNT = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_ROOM  = 4'b0100,
    PH_TILE  = 4'b1000
  } cbrp_phase_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SQ_IDX_W-1:0] square_index;
    logic [WORD_W-1:0]   room_id;
    logic [CNT8_W-1:0]   tile_count;
    logic [WORD_W-1:0]   tile_value;
    logic [CNT8_W-1:0]   tile_slot;
    logic [2:0]          status;
    logic [SQ_CNT_W-1:0] squares_covered;
    logic                last;
  } cbrp_result_t;

  typedef struct packed {
    logic [1:0]   push_n;
    cbrp_result_t res_a;
    cbrp_result_t res_b;
  } cbrp_push_t;

endpackage

// ===== src/cbrp_core.sv =====
module cbrp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [cbrp_pkg::WORD_W-1:0]   word,
  input  logic                          last_word,
  output cbrp_pkg::cbrp_push_t          push
);
  import cbrp_pkg::*;

  cbrp_phase_t         phase_r, phase_nxt;
  logic [SQ_CNT_W-1:0] sq_r, sq_nxt;
  logic [CNT8_W-1:0]   tiles_r, tiles_nxt;
  logic [CNT8_W-1:0]   slot_r, slot_nxt;
  logic [CNT8_W-1:0]   pend_r, pend_nxt;
  logic [2:0]          err_r, err_nxt;

  logic [WORD_W-1:0]   word_m1;
  logic [WORD_W:0]     skip_sum;
  logic [CNT8_W-1:0]   tiles_dec;
  cbrp_result_t        res;
  cbrp_result_t        fin;
  logic                has_res;
  logic [2:0]          fin_status;

  assign word_m1   = word - WORD_W'(1);
  assign skip_sum  = (WORD_W+1)'(sq_r) + {1'b0, word};
  assign tiles_dec = tiles_r - CNT8_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    sq_nxt     = sq_r;
    tiles_nxt  = tiles_r;
    slot_nxt   = slot_r;
    pend_nxt   = pend_r;
    err_nxt    = err_r;
    res        = '0;
    fin        = '0;
    has_res    = 1'b0;
    fin_status = ST_OK;
    push       = '0;

    if (fire && err_r == ST_OK) begin
      unique case (phase_r)
        PH_COUNT: begin
          priority if (word == SKIP_MARK) begin
            phase_nxt = PH_SKIP;
          end else if (word[WORD_W-1] || word == '0 || word > WORD_W'(MAX_COUNT)) begin
            err_nxt = ST_BAD_COUNT;
          end else if (sq_r >= SQ_CNT_W'(TOTAL_SQUARES)) begin
            err_nxt = ST_TOO_MANY;
          end else begin
            pend_nxt  = word_m1[CNT8_W-1:0];
            phase_nxt = PH_ROOM;
          end
        end
        PH_SKIP: begin
          priority if (word[WORD_W-1] || word == '0) begin
            err_nxt = ST_BAD_RUN;
          end else if (skip_sum > (WORD_W+1)'(TOTAL_SQUARES)) begin
            err_nxt = ST_OVERSHOOT;
          end else begin
            sq_nxt    = skip_sum[SQ_CNT_W-1:0];
            phase_nxt = PH_COUNT;
          end
        end
        PH_ROOM: begin
          has_res          = 1'b1;
          res.kind         = KIND_HEADER;
          res.square_index = sq_r[SQ_IDX_W-1:0];
          res.room_id      = word;
          res.tile_count   = pend_r;
          if (pend_r == '0) begin
            sq_nxt    = sq_r + SQ_CNT_W'(1);
            phase_nxt = PH_COUNT;
          end else begin
            tiles_nxt = pend_r;
            slot_nxt  = '0;
            phase_nxt = PH_TILE;
          end
        end
        PH_TILE: begin
          has_res          = 1'b1;
          res.kind         = KIND_TILE;
          res.square_index = sq_r[SQ_IDX_W-1:0];
          res.tile_value   = word;
          res.tile_slot    = slot_r;
          slot_nxt         = slot_r + CNT8_W'(1);
          tiles_nxt        = tiles_dec;
          if (tiles_dec == '0) begin
            sq_nxt    = sq_r + SQ_CNT_W'(1);
            phase_nxt = PH_COUNT;
          end
        end
        default: begin
          phase_nxt = PH_COUNT;
        end
      endcase
    end

    if (err_nxt != ST_OK) begin
      fin_status = err_nxt;
    end else if (phase_nxt != PH_COUNT) begin
      fin_status = ST_TRUNCATED;
    end
    fin.kind            = KIND_FINISH;
    fin.status          = fin_status;
    fin.squares_covered = sq_nxt;
    fin.last            = 1'b1;

    if (fire) begin
      if (last_word) begin
        if (has_res) begin
          push.push_n = 2'd2;
          push.res_a  = res;
          push.res_b  = fin;
        end else begin
          push.push_n = 2'd1;
          push.res_a  = fin;
        end
        phase_nxt = PH_COUNT;
        sq_nxt    = '0;
        tiles_nxt = '0;
        slot_nxt  = '0;
        pend_nxt  = '0;
        err_nxt   = ST_OK;
      end else if (has_res) begin
        push.push_n = 2'd1;
        push.res_a  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      sq_r    <= '0;
      tiles_r <= '0;
      slot_r  <= '0;
      pend_r  <= '0;
      err_r   <= ST_OK;
    end else begin
      phase_r <= phase_nxt;
      sq_r    <= sq_nxt;
      tiles_r <= tiles_nxt;
      slot_r  <= slot_nxt;
      pend_r  <= pend_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== src/cbrp_out_queue.sv =====
module cbrp_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cbrp_pkg::cbrp_push_t   push,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cbrp_pkg::cbrp_result_t head
);
  import cbrp_pkg::*;

  cbrp_result_t     mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0] count_r, count_nxt;
  logic [OQ_AW-1:0] wr_ptr_p1;
  logic             pop;

  assign out_valid = count_r != '0;
  assign head      = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign space     = count_r <= OQ_CW'(OQ_DEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + OQ_AW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_AW'(push.push_n);
    rd_ptr_nxt = pop ? rd_ptr_r + OQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + OQ_CW'(push.push_n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push_n != 2'd0) begin
      mem[wr_ptr_r] <= push.res_a;
    end
    if (push.push_n == 2'd2) begin
      mem[wr_ptr_p1] <= push.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/chunk_body_record_parser.sv =====
// chunk body record parser
// input channel: in_valid / in_stall carry one 32-bit signed word of a chunk body
//   per item, with in_last_word set on the final word of the body
// result channel: out_valid / out_stall carry one result per item: a square
//   header, a tile entry or the chunk finish (out_last set) with its status
// a word yields zero, one or two results; the final word always yields the
//   finish result, after any header or tile result of its own
// a taken word waits in the input register; when it fires it is parsed and its
//   results are written into the result queue, whose head drives the outputs
// throughput: one word per cycle while each word gives at most one result and
//   the receiver does not stall; the result channel moves one result per cycle,
//   so a final word that gives two results leaves an extra result to drain
// the parser state sits after the input register; a four-entry result queue
//   takes both of a word's results at once and admits a word while it has room
//   for two results
// a stalled receiver fills the queue, then the input register holds its word
//   and in_stall rises; nothing is dropped
// reset (rst_n low, synchronous) empties the queue and the input register and
//   puts the parser at the start of a body
module chunk_body_record_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cbrp_pkg::WORD_W-1:0]   in_word,
  input  logic                                 in_last_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_kind,
  output logic [cbrp_pkg::SQ_IDX_W-1:0]        out_square_index,
  output logic signed [cbrp_pkg::WORD_W-1:0]   out_room_id,
  output logic [cbrp_pkg::CNT8_W-1:0]          out_tile_count,
  output logic signed [cbrp_pkg::WORD_W-1:0]   out_tile_value,
  output logic [cbrp_pkg::CNT8_W-1:0]          out_tile_slot,
  output logic [2:0]                           out_status,
  output logic [cbrp_pkg::SQ_CNT_W-1:0]        out_squares_covered,
  output logic                                 out_last
);
  import cbrp_pkg::*;

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic              last_r;
  logic              space;
  logic              fire;
  logic              in_take;
  cbrp_push_t        push;
  cbrp_result_t      head;

  assign fire     = valid_r && space;
  assign in_stall = valid_r && !space;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (in_take) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      word_r <= in_word;
      last_r <= in_last_word;
    end
  end

  cbrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .word      (word_r),
    .last_word (last_r),
    .push      (push)
  );

  cbrp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind            = head.kind;
  assign out_square_index    = head.square_index;
  assign out_room_id         = head.room_id;
  assign out_tile_count      = head.tile_count;
  assign out_tile_value      = head.tile_value;
  assign out_tile_slot       = head.tile_slot;
  assign out_status          = head.status;
  assign out_squares_covered = head.squares_covered;
  assign out_last            = head.last;

endmodule

// ===== src/cbrp_checker.sv =====
`include "assert_macros.svh"

module cbrp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [1:0]                           out_kind,
  input logic [cbrp_pkg::SQ_IDX_W-1:0]        out_square_index,
  input logic signed [cbrp_pkg::WORD_W-1:0]   out_room_id,
  input logic [cbrp_pkg::CNT8_W-1:0]          out_tile_count,
  input logic signed [cbrp_pkg::WORD_W-1:0]   out_tile_value,
  input logic [cbrp_pkg::CNT8_W-1:0]          out_tile_slot,
  input logic [2:0]                           out_status,
  input logic [cbrp_pkg::SQ_CNT_W-1:0]        out_squares_covered,
  input logic                                 out_last
);
  import cbrp_pkg::*;

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall,
                 "result or input stall after reset")
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_kind)
              && $stable(out_last) && $stable(out_status), "stalled result changed")
  `ASSERT_CLK(a_last_is_finish, out_valid |-> (out_last == (out_kind == KIND_FINISH)),
              "last flag and kind disagree")
  `ASSERT_CLK(a_record_clean, out_valid && !out_last |-> out_status == ST_OK
              && out_squares_covered == '0, "status on a record result")
  `ASSERT_CLK(a_finish_clean, out_valid && out_last |-> out_room_id == '0
              && out_tile_value == '0 && out_tile_slot == '0 && out_square_index == '0
              && out_tile_count == '0, "payload on a finish result")

endmodule

bind chunk_body_record_parser cbrp_checker u_cbrp_checker (.*);
